[rtl/lfd_pkg.sv]
package lfd_pkg;

    localparam int CHANNELS_DEF = 9;
    localparam int LEVELS_DEF   = 10;

    localparam int LEVEL_W    = 4;
    localparam int PHASE_W    = 4;
    localparam int STEP_W     = 11;
    localparam int LED_W      = 9;
    localparam int ENABLE_W   = 9;
    localparam int INTERVAL_W = 10;
    localparam int CHAN_W     = 4;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    localparam logic [PHASE_W-1:0] PHASE_MAX = '1;
    localparam logic [STEP_W-1:0]  STEP_MAX  = '1;

    localparam logic [ENABLE_W-1:0]   ENABLE_RESET   = 9'd254;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd20;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_INTERVAL  = 1'd1;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [LEVEL_W-1:0] level;
    } run_entry_t;

endpackage

[rtl/lfd_ram.sv]
module lfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 9,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/led_pwm_fader_top.sv]
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tuser: req_type; tdata: channel, target_level
// m_*       out        m_tvalid/m_tready  tdata: led_on
// cfg_*     in         cfg_we             cfg_index, cfg_data
//
// A set-target item writes the goal memory and loads its result at the accepting edge.
// A tick item walks all channels through the state memories, one read per cycle, and
// writes back each enabled channel in the cycle after its read. Its result is loaded
// after the last write-back, and the next item is taken once the block is idle again.
// Reset is asynchronous; per-entry valid bits make unwritten entries read as zero.
// A new item is taken only in idle, and only when the output register is free or drains.
module led_pwm_fader_top
    import lfd_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int LEVELS   = LEVELS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [3:0] channel, [7:4] target_level
    input  logic                  s_tuser,   // [0] req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [8:0] led_on, rest zero
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW  = $clog2(CHANNELS + 1);
    localparam int XW  = (CHANNELS > LED_W) ? CHANNELS : LED_W;
    localparam int CXW = (AW > CHAN_W) ? AW : CHAN_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    localparam logic [LEVEL_W-1:0] LEVEL_TOP = LEVEL_W'(LEVELS);

    logic                  state_reg, state_next;
    logic [CW-1:0]         issue_reg, issue_next;
    logic                  proc_valid_reg, proc_valid_next;
    logic [AW-1:0]         proc_idx_reg, proc_idx_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [CHANNELS-1:0]   pin_reg, pin_next;
    logic [CHANNELS-1:0]   run_vld_reg, run_vld_next;
    logic [CHANNELS-1:0]   goal_vld_reg, goal_vld_next;
    logic                  out_valid_reg, out_valid_next;
    logic [LED_W-1:0]      led_reg, led_next;
    logic [ENABLE_W-1:0]   enable_reg;
    logic [INTERVAL_W-1:0] interval_reg;

    logic                  accept;
    logic                  issuing;
    logic [CXW-1:0]        ch_ext;
    logic [LEVEL_W-1:0]    tgt_in, tgt_clamped;
    logic                  goal_we;
    logic [AW-1:0]         rd_addr;
    run_entry_t            run_rdata, run_cur, run_wdata;
    logic [LEVEL_W-1:0]    goal_rdata, goal_cur;
    logic                  run_we;
    logic [XW-1:0]         pin_ext, en_ext;
    logic                  hit, pin_cur, pin_new;
    logic [LEVEL_W-1:0]    lvl, off_len;
    logic [PHASE_W-1:0]    phase;

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(led_reg);

    assign ch_ext      = CXW'(s_tdata[CHAN_W-1:0]);
    assign tgt_in      = s_tdata[CHAN_W +: LEVEL_W];
    assign tgt_clamped = (tgt_in > LEVEL_TOP) ? LEVEL_TOP : tgt_in;
    assign goal_we     = accept && (s_tuser == REQ_SET)
                         && (ch_ext < CXW'(CHANNELS));

    assign issuing = (state_reg == ST_RUN) && (issue_reg < CW'(CHANNELS));
    assign rd_addr = issue_reg[AW-1:0];

    assign pin_ext = XW'(pin_reg);
    assign en_ext  = XW'(enable_reg);

    lfd_ram #(
        .WIDTH ($bits(run_entry_t)),
        .DEPTH (CHANNELS)
    ) u_run_ram (
        .clk   (clk),
        .we    (run_we),
        .waddr (proc_idx_reg),
        .wdata (run_wdata),
        .re    (issuing),
        .raddr (rd_addr),
        .rdata (run_rdata)
    );

    lfd_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (CHANNELS)
    ) u_goal_ram (
        .clk   (clk),
        .we    (goal_we),
        .waddr (ch_ext[AW-1:0]),
        .wdata (tgt_clamped),
        .re    (issuing),
        .raddr (rd_addr),
        .rdata (goal_rdata)
    );

    always_comb
    begin
        run_cur  = run_vld_reg[proc_idx_reg] ? run_rdata : '0;
        goal_cur = goal_vld_reg[proc_idx_reg] ? goal_rdata : '0;
        pin_cur  = pin_reg[proc_idx_reg];
        hit      = (step_reg == STEP_W'(interval_reg));

        lvl = run_cur.level;
        if (hit)
        begin
            if (goal_cur > lvl)
            begin
                lvl = lvl + 1'b1;
            end
            else if (goal_cur < lvl)
            begin
                lvl = lvl - 1'b1;
            end
        end
        off_len = LEVEL_TOP - lvl;

        phase   = run_cur.phase;
        pin_new = pin_cur;
        if (pin_cur)
        begin
            if ((PHASE_W'(lvl) <= phase) && (off_len != '0))
            begin
                pin_new = 1'b0;
                phase   = '0;
            end
        end
        else
        begin
            if ((PHASE_W'(off_len) <= phase) && (lvl != '0))
            begin
                pin_new = 1'b1;
                phase   = '0;
            end
        end
        if (phase != PHASE_MAX)
        begin
            phase = phase + 1'b1;
        end

        run_wdata.level = lvl;
        run_wdata.phase = phase;
        run_we = proc_valid_reg && en_ext[proc_idx_reg];
    end

    always_comb
    begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        proc_valid_next = 1'b0;
        proc_idx_next   = proc_idx_reg;
        step_next       = step_reg;
        pin_next        = pin_reg;
        run_vld_next    = run_vld_reg;
        goal_vld_next   = goal_vld_reg;
        out_valid_next  = out_valid_reg;
        led_next        = led_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (goal_we)
        begin
            goal_vld_next[ch_ext[AW-1:0]] = 1'b1;
        end

        if (accept)
        begin
            if (s_tuser == REQ_SET)
            begin
                out_valid_next = 1'b1;
                led_next       = pin_ext[LED_W-1:0];
            end
            else
            begin
                state_next = ST_RUN;
                issue_next = '0;
            end
        end

        if (issuing)
        begin
            proc_valid_next = 1'b1;
            proc_idx_next   = rd_addr;
            issue_next      = issue_reg + 1'b1;
        end

        if (run_we)
        begin
            run_vld_next[proc_idx_reg] = 1'b1;
            pin_next[proc_idx_reg]     = pin_new;
            if (hit)
            begin
                step_next = STEP_W'(1);
            end
            else if (step_reg != STEP_MAX)
            begin
                step_next = step_reg + 1'b1;
            end
        end

        if ((state_reg == ST_RUN) && !issuing && !proc_valid_reg)
        begin
            state_next     = ST_IDLE;
            out_valid_next = 1'b1;
            led_next       = pin_ext[LED_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_reg      <= '0;
            proc_valid_reg <= 1'b0;
            proc_idx_reg   <= '0;
            step_reg       <= '0;
            pin_reg        <= '0;
            run_vld_reg    <= '0;
            goal_vld_reg   <= '0;
            out_valid_reg  <= 1'b0;
            enable_reg     <= ENABLE_RESET;
            interval_reg   <= INTERVAL_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            issue_reg      <= issue_next;
            proc_valid_reg <= proc_valid_next;
            proc_idx_reg   <= proc_idx_next;
            step_reg       <= step_next;
            pin_reg        <= pin_next;
            run_vld_reg    <= run_vld_next;
            goal_vld_reg   <= goal_vld_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CHANNEL_ENABLE: enable_reg   <= cfg_data[ENABLE_W-1:0];
                    REG_RAMP_INTERVAL:  interval_reg <= cfg_data[INTERVAL_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        led_reg <= led_next;
    end

endmodule
